>>> rtl/core/lkst_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-to-slot table package
// Field widths, request kinds, default sizes and the cell control word.
// ----------------------------------------------------------------------------
package lkst_pkg;

   // Widths of the channel fields.
   localparam int KIND_W = 2;
   localparam int KEY_W  = 16;
   localparam int SLOT_W = 5;

   // Default table dimensions.
   localparam int DEF_SLOTS    = 32;
   localparam int DEF_KEY_BITS = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CONFIRM = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK    = 2'd2;

   // Control handed from the sequencer to each cell of the chain.
   typedef struct packed {
      logic shift;     // take the entry of the next more recent cell
      logic set_conf;  // set this cell's confirmed mark
   } lkst_cell_ctrl_type;

endpackage

>>> rtl/core/lkst_if.sv
// ----------------------------------------------------------------------------
// LRU key-to-slot table channels
// Request and response channels, each with valid, ready and the word fields.
// ----------------------------------------------------------------------------
interface lkst_req_if import lkst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [KEY_W-1:0]  key;
   logic [SLOT_W-1:0] slot_in;

   modport source (output valid, kind, key, slot_in, input ready);
   modport sink   (input valid, kind, key, slot_in, output ready);
endinterface

interface lkst_rsp_if import lkst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic              hit;
   logic              confirmed;
   logic              new_mapping;

   modport source (output valid, slot, hit, confirmed, new_mapping, input ready);
   modport sink   (input valid, slot, hit, confirmed, new_mapping, output ready);
endinterface

>>> rtl/core/lkst_cell.sv
// ----------------------------------------------------------------------------
// LRU key-to-slot table cell
// One recency position: holds a slot number with its key, valid bit and
// confirmed mark, compares them against the request and can take over the
// entry of its more recent neighbour.
// ----------------------------------------------------------------------------
module lkst_cell
   import lkst_pkg::*;
#(
   parameter int ID_W  = 5,
   parameter int KW    = 16,
   parameter int IDW   = 5,
   parameter int POS   = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  lkst_cell_ctrl_type ctrl,
   input  logic [KW-1:0]      cmp_key,
   input  logic [IDW-1:0]     cmp_id,
   input  logic [ID_W-1:0]    nxt_id,
   input  logic [KW-1:0]      nxt_key,
   input  logic               nxt_valid,
   input  logic               nxt_conf,
   output logic [ID_W-1:0]    cur_id,
   output logic [KW-1:0]      cur_key,
   output logic               cur_valid,
   output logic               cur_conf,
   output logic               key_match,
   output logic               id_match
);

   logic [ID_W-1:0] id_ff,    id_in;
   logic [KW-1:0]   key_ff,   key_in;
   logic            valid_ff, valid_in;
   logic            conf_ff,  conf_in;

   // A shift takes the neighbour's entry; a confirm only sets the mark.
   always_comb begin
      id_in    = id_ff;
      key_in   = key_ff;
      valid_in = valid_ff;
      conf_in  = conf_ff;
      if (ctrl.shift) begin
         id_in    = nxt_id;
         key_in   = nxt_key;
         valid_in = nxt_valid;
         conf_in  = nxt_conf;
      end else if (ctrl.set_conf) begin
         conf_in = 1'b1;
      end
   end

   // Reset leaves the slots in order from least to most recent.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff    <= ID_W'(POS);
         key_ff   <= '0;
         valid_ff <= 1'b0;
         conf_ff  <= 1'b0;
      end else begin
         id_ff    <= id_in;
         key_ff   <= key_in;
         valid_ff <= valid_in;
         conf_ff  <= conf_in;
      end
   end

   // Compares against the request on the channel.
   assign key_match = valid_ff && (key_ff == cmp_key);
   assign id_match  = (IDW'(id_ff) == cmp_id);

   assign cur_id    = id_ff;
   assign cur_key   = key_ff;
   assign cur_valid = valid_ff;
   assign cur_conf  = conf_ff;

endmodule

>>> rtl/core/lru_key_to_slot_table_top.sv
// ----------------------------------------------------------------------------
// LRU key-to-slot table
// Fully associative map of keys to slots with least-recently-used
// replacement, built as a chain of cells ordered by recency.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word fields
//   req_     in         kind, key, slot_in
//   rsp_     out        slot, hit, confirmed, new_mapping
//
// For each word, every cell compares its key and slot number against the
// request in the cycle the word is accepted; in the update state that
// follows, a check shifts the chain by one position to move the used slot
// to the most recent end. Reset puts every cell into its reset state. A
// response that has not been taken holds the update state back; a new request
// is taken as soon as the previous update is done.
//
module lru_key_to_slot_table_top
   import lkst_pkg::*;
#(
   parameter int SLOTS    = DEF_SLOTS,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic      clock,
   input  logic      reset,
   lkst_req_if.sink  req_port,
   lkst_rsp_if.source rsp_port
);

   localparam int SW  = $clog2(SLOTS);
   localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int IDW = (SW > SLOT_W) ? SW : SLOT_W;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Stored request.
   logic [KIND_W-1:0] kind_ff;
   logic [KW-1:0]     key_ff;
   logic [SLOT_W-1:0] sin_ff;
   logic [SLOTS-1:0]  mk_ff;
   logic [SLOTS-1:0]  mid_ff;

   // Cell views.
   logic [SW-1:0]      c_id    [SLOTS];
   logic [KW-1:0]      c_key   [SLOTS];
   logic               c_valid [SLOTS];
   logic               c_conf  [SLOTS];
   logic [SLOTS-1:0]   mk_c;
   logic [SLOTS-1:0]   mid_c;
   lkst_cell_ctrl_type ctrl    [SLOTS];

   // Entry moved into the most recent cell.
   logic [SW-1:0] top_id;
   logic [KW-1:0] top_key;
   logic          top_conf;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_hit_ff;
   logic              rsp_conf_ff;
   logic              rsp_new_ff;

   logic              accept;
   logic              out_free;
   logic              upd;
   logic              any_hit;
   logic [SLOTS-1:0]  sel;
   logic [SLOTS-1:0]  pre;
   logic [SW-1:0]     g_id;
   logic              g_conf;
   logic [IDW-1:0]    g_wide;
   logic              c_hit;
   logic              c_conf_r;
   logic [SLOT_W-1:0] r_slot;
   logic              r_hit;
   logic              r_conf;
   logic              r_new;

   assign accept   = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign upd      = (state_ff == ST_UPDATE) && out_free;

   assign req_port.ready = (state_ff == ST_IDLE);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Capture the request and the compare results of every cell.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_port.kind;
         key_ff  <= req_port.key[KW-1:0];
         sin_ff  <= req_port.slot_in;
         mk_ff   <= mk_c;
         mid_ff  <= mid_c;
      end
   end

   // Select the used cell: the hit, or the least recent cell on a check miss.
   always_comb begin
      any_hit = |mk_ff;
      if (kind_ff == KIND_CHECK && !any_hit) sel = SLOTS'(1);
      else                                   sel = mk_ff;
   end

   // Every cell at or above the used position shifts down by one.
   always_comb begin
      pre = sel;
      for (int d = 1; d < SLOTS; d = d * 2) begin
         pre = pre | (pre << d);
      end
   end

   // Gather the selected entry; at most one cell is selected.
   always_comb begin
      g_id   = '0;
      g_conf = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (sel[i]) begin
            g_id   = g_id | c_id[i];
            g_conf = g_conf | c_conf[i];
         end
      end
      g_wide = IDW'(g_id);
   end

   // Confirm: the named slot must still hold the key.
   always_comb begin
      c_hit    = |(mid_ff & mk_ff);
      c_conf_r = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (mid_ff[i]) c_conf_r = c_conf_r | c_conf[i] | mk_ff[i];
      end
   end

   assign top_id   = g_id;
   assign top_key  = key_ff;
   assign top_conf = any_hit && g_conf;

   // Cell control.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         ctrl[i].shift    = upd && (kind_ff == KIND_CHECK) && pre[i];
         ctrl[i].set_conf = upd && (kind_ff == KIND_CONFIRM) && mid_ff[i] && mk_ff[i];
      end
   end

   // Chain of cells, least recent first.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [SW-1:0] n_id;
      logic [KW-1:0] n_key;
      logic          n_valid;
      logic          n_conf;

      if (i == SLOTS - 1) begin : g_last
         assign n_id    = top_id;
         assign n_key   = top_key;
         assign n_valid = 1'b1;
         assign n_conf  = top_conf;
      end else begin : g_mid
         assign n_id    = c_id[i+1];
         assign n_key   = c_key[i+1];
         assign n_valid = c_valid[i+1];
         assign n_conf  = c_conf[i+1];
      end

      lkst_cell #(
         .ID_W (SW),
         .KW   (KW),
         .IDW  (IDW),
         .POS  (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[i]),
         .cmp_key   (req_port.key[KW-1:0]),
         .cmp_id    (IDW'(req_port.slot_in)),
         .nxt_id    (n_id),
         .nxt_key   (n_key),
         .nxt_valid (n_valid),
         .nxt_conf  (n_conf),
         .cur_id    (c_id[i]),
         .cur_key   (c_key[i]),
         .cur_valid (c_valid[i]),
         .cur_conf  (c_conf[i]),
         .key_match (mk_c[i]),
         .id_match  (mid_c[i])
      );
   end

   // Response word for each kind of request.
   always_comb begin
      r_slot = '0;
      r_hit  = 1'b0;
      r_conf = 1'b0;
      r_new  = 1'b0;
      case (kind_ff)
         KIND_CHECK: begin
            r_slot = g_wide[SLOT_W-1:0];
            r_hit  = any_hit;
            r_conf = any_hit && g_conf;
            r_new  = !any_hit;
         end
         KIND_CONFIRM: begin
            r_slot = sin_ff;
            r_hit  = c_hit;
            r_conf = c_conf_r;
         end
         KIND_PEEK: begin
            if (any_hit) begin
               r_slot = g_wide[SLOT_W-1:0];
               r_hit  = 1'b1;
               r_conf = g_conf;
            end
         end
         default: begin
            r_slot = '0;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_port.ready) rsp_valid_in = 1'b0;
      if (upd)            rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         rsp_slot_ff <= r_slot;
         rsp_hit_ff  <= r_hit;
         rsp_conf_ff <= r_conf;
         rsp_new_ff  <= r_new;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.slot        = rsp_slot_ff;
   assign rsp_port.hit         = rsp_hit_ff;
   assign rsp_port.confirmed   = rsp_conf_ff;
   assign rsp_port.new_mapping = rsp_new_ff;

endmodule
